// ===== src/decision_tree_inference_defines.svh =====
// Assertion macros used by the checker file of the decision tree block
`ifndef DECISION_TREE_INFERENCE_DEFINES_SVH
`define DECISION_TREE_INFERENCE_DEFINES_SVH

// Implication that must hold in the same cycle, outside reset
`define DTI_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle
`define DTI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dti_pkg.sv =====
// Shared types and constants of the decision tree inference block
package dti_pkg;

    localparam int DTI_MAX_SPLITS   = 256;
    localparam int DTI_NUM_FEATURES = 63;
    localparam int DTI_NODE_BITS    = 16;

    localparam int PARENT_W = 16;
    localparam int FIDX_W   = 6;
    localparam int VAL_W    = 32;
    localparam int CLASS_W  = 8;
    localparam int LEAF_W   = 16;

    typedef enum logic [1:0] {
        FUNC_CLEAR    = 2'd0,
        FUNC_APPEND   = 2'd1,
        FUNC_WR_FEAT  = 2'd2,
        FUNC_CLASSIFY = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        W_IDLE,
        W_SCAN,
        W_HOLD
    } walk_state_t;

    typedef struct packed {
        logic [PARENT_W-1:0] parent;
        logic [FIDX_W-1:0]   feature;
        logic [VAL_W-1:0]    threshold;
        logic [CLASS_W-1:0]  left_cls;
        logic [CLASS_W-1:0]  right_cls;
    } split_entry_t;

    typedef struct packed {
        logic start;
        logic in_bag;
    } walk_req_t;

    typedef struct packed {
        logic               idle;
        logic               res_valid;
        logic [CLASS_W-1:0] predicted_class;
        logic               valid_res;
        logic [LEAF_W-1:0]  leaf_node;
    } walk_stat_t;

endpackage

// ===== src/dti_split_table.sv =====
// Split table memory with append pointer and one registered read port
module dti_split_table #(
    parameter int MAX_SPLITS = dti_pkg::DTI_MAX_SPLITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic                          append,
    input  dti_pkg::split_entry_t         wr_entry,
    input  logic                          rd_en,
    input  logic [((MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1)-1:0] rd_addr,
    output dti_pkg::split_entry_t         rd_data,
    output logic [$clog2(MAX_SPLITS+1)-1:0] count
);
    import dti_pkg::*;

    localparam int TAW  = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
    localparam int CNTW = $clog2(MAX_SPLITS + 1);

    split_entry_t        mem [MAX_SPLITS];
    split_entry_t        rd_data_reg;
    logic [CNTW-1:0]     count_reg;
    logic [CNTW-1:0]     count_next;
    logic                full;

    assign full = (count_reg == CNTW'(MAX_SPLITS));

    always_comb begin
        count_next = count_reg;
        if (clear) begin
            count_next = '0;
        end else if (append && !full) begin
            count_next = count_reg + CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // full table: append dropped
    always_ff @(posedge aclk) begin
        if (append && !full) begin
            mem[count_reg[TAW-1:0]] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

// ===== src/dti_feature_store.sv =====
// Feature value memory; per-slot valid bits make unwritten slots read as zero
module dti_feature_store #(
    parameter int NUM_FEATURES = dti_pkg::DTI_NUM_FEATURES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [dti_pkg::FIDX_W-1:0]  wr_idx,
    input  logic [dti_pkg::VAL_W-1:0]   wr_data,
    input  logic                        rd_en,
    input  logic [dti_pkg::FIDX_W-1:0]  rd_idx,
    output logic [dti_pkg::VAL_W-1:0]   rd_data
);
    import dti_pkg::*;

    // slot index is 6 bits wide, so at most 64 slots are reachable
    localparam int FS_DEPTH = (NUM_FEATURES + 1 < (1 << FIDX_W)) ?
                              (NUM_FEATURES + 1) : (1 << FIDX_W);
    localparam int FS_AW    = (FS_DEPTH > 1) ? $clog2(FS_DEPTH) : 1;

    logic [VAL_W-1:0] mem [FS_DEPTH];
    logic [FS_DEPTH-1:0] vld_reg;
    logic [VAL_W-1:0] rd_data_reg;
    logic             rd_hit_reg;
    logic             wr_in_range;
    logic             rd_in_range;

    assign wr_in_range = ({26'd0, wr_idx} <= 32'(NUM_FEATURES));
    assign rd_in_range = ({26'd0, rd_idx} <= 32'(NUM_FEATURES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en && wr_in_range) begin
                vld_reg[wr_idx[FS_AW-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= rd_in_range && vld_reg[rd_idx[FS_AW-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_in_range) begin
            mem[wr_idx[FS_AW-1:0]] <= wr_data;
        end
        if (rd_en && rd_in_range) begin
            rd_data_reg <= mem[rd_idx[FS_AW-1:0]];
        end
    end

    // slots beyond the store and unwritten slots read as zero
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ===== src/dti_walker.sv =====
// Tree walk sequencer: streams the split table through a three-stage read pipe
module dti_walker #(
    parameter int MAX_SPLITS = dti_pkg::DTI_MAX_SPLITS,
    parameter int NODE_BITS  = dti_pkg::DTI_NODE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dti_pkg::walk_req_t              req,
    input  logic                            res_ready,
    input  logic [$clog2(MAX_SPLITS+1)-1:0] count,
    output logic                            tbl_rd_en,
    output logic [((MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1)-1:0] tbl_rd_addr,
    input  dti_pkg::split_entry_t           tbl_rd_data,
    output logic                            feat_rd_en,
    output logic [dti_pkg::FIDX_W-1:0]      feat_rd_idx,
    input  logic [dti_pkg::VAL_W-1:0]       feat_rd_data,
    output dti_pkg::walk_stat_t             stat
);
    import dti_pkg::*;

    localparam int TAW  = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
    localparam int CNTW = $clog2(MAX_SPLITS + 1);
    localparam int CW   = (NODE_BITS > PARENT_W) ? NODE_BITS : PARENT_W;

    walk_state_t         state_reg,  state_next;
    logic [CNTW-1:0]     idx_reg,    idx_next;
    logic [CNTW-1:0]     n_reg,      n_next;
    logic                v1_reg,     v1_next;
    logic                v2_reg,     v2_next;
    logic [NODE_BITS-1:0] node_reg,  node_next;
    logic [CLASS_W-1:0]  cls_reg,    cls_next;
    logic                hit_reg,    hit_next;
    logic [LEAF_W-1:0]   leaf_reg,   leaf_next;
    split_entry_t        e2_reg;
    logic                issue;
    logic                match;
    logic                go_right;
    logic [NODE_BITS-1:0] node_dbl;

    assign issue       = (state_reg == W_SCAN) && (idx_reg < n_reg);
    assign tbl_rd_en   = issue;
    assign tbl_rd_addr = idx_reg[TAW-1:0];

    // stage 2: feature address comes straight from the table read
    assign feat_rd_en  = v1_reg;
    assign feat_rd_idx = tbl_rd_data.feature;

    // stage 3: parent compare against the live node, then step down
    assign match    = v2_reg && (CW'(node_reg) == CW'(e2_reg.parent));
    assign go_right = $signed(feat_rd_data) > $signed(e2_reg.threshold);
    assign node_dbl = node_reg << 1;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        v1_next    = issue;
        v2_next    = v1_reg;
        node_next  = node_reg;
        cls_next   = cls_reg;
        hit_next   = hit_reg;
        leaf_next  = leaf_reg;

        case (state_reg)
            W_IDLE: begin
                if (req.start) begin
                    node_next = NODE_BITS'(1);
                    cls_next  = '0;
                    hit_next  = 1'b0;
                    idx_next  = '0;
                    n_next    = count;
                    if (req.in_bag) begin
                        leaf_next  = '0;
                        state_next = W_HOLD;
                    end else if (count == '0) begin
                        leaf_next  = LEAF_W'(1);
                        state_next = W_HOLD;
                    end else begin
                        state_next = W_SCAN;
                    end
                end
            end
            W_SCAN: begin
                if (issue) begin
                    idx_next = idx_reg + CNTW'(1);
                end
                if (match) begin
                    hit_next = 1'b1;
                    if (go_right) begin
                        node_next = node_dbl | NODE_BITS'(1);
                        cls_next  = e2_reg.right_cls;
                    end else begin
                        node_next = node_dbl;
                        cls_next  = e2_reg.left_cls;
                    end
                end
                if (!issue && !v1_reg && !v2_reg) begin
                    leaf_next  = LEAF_W'(node_reg);
                    state_next = W_HOLD;
                end
            end
            W_HOLD: begin
                if (res_ready) begin
                    state_next = W_IDLE;
                end
            end
            default: begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
            idx_reg   <= '0;
            n_reg     <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
        cls_reg  <= cls_next;
        leaf_reg <= leaf_next;
        if (v1_reg) begin
            e2_reg <= tbl_rd_data;
        end
    end

    always_comb begin
        stat.idle            = (state_reg == W_IDLE);
        stat.res_valid       = (state_reg == W_HOLD);
        stat.predicted_class = hit_reg ? cls_reg : '0;
        stat.valid_res       = hit_reg;
        stat.leaf_node       = leaf_reg;
    end

endmodule

// ===== src/decision_tree_inference.sv =====
// Write items take effect when accepted; a classify transaction streams its n stored
//   splits through the walker's read pipe (no scan when in-bag or table empty).
// Throughput: one split entry per cycle, set by the table read port feeding the
//   feature read port; after a classify, the next transaction is taken only once
//   the walker has handed off its result to the output register and gone idle.
// Reset: aresetn, synchronous, active low; clears split count and feature valid bits.
module decision_tree_inference #(
    parameter int MAX_SPLITS   = dti_pkg::DTI_MAX_SPLITS,
    parameter int NUM_FEATURES = dti_pkg::DTI_NUM_FEATURES,
    parameter int NODE_BITS    = dti_pkg::DTI_NODE_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] node_id, [21:16] feature_index, [53:22] threshold,
    // [61:54] left class, [69:62] right class, [101:70] feature_value,
    // [102] in_bag, [103] zero pad
    input  logic [103:0] s_tdata,
    // [1:0] func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] predicted_class, [8] valid_res, [24:9] leaf_node, [31:25] zero pad
    output logic [31:0]  m_tdata
);
    import dti_pkg::*;

    localparam int TAW  = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
    localparam int CNTW = $clog2(MAX_SPLITS + 1);

    // field unpack
    logic [PARENT_W-1:0] node_id;
    logic [FIDX_W-1:0]   feature_index;
    logic [VAL_W-1:0]    threshold;
    logic [CLASS_W-1:0]  left_cls;
    logic [CLASS_W-1:0]  right_cls;
    logic [VAL_W-1:0]    feature_value;
    logic                in_bag;
    func_t               func;

    assign node_id       = s_tdata[15:0];
    assign feature_index = s_tdata[21:16];
    assign threshold     = s_tdata[53:22];
    assign left_cls      = s_tdata[61:54];
    assign right_cls     = s_tdata[69:62];
    assign feature_value = s_tdata[101:70];
    assign in_bag        = s_tdata[102];
    assign func          = func_t'(s_tuser);

    logic                accept;
    logic                do_clear;
    logic                do_append;
    logic                do_wr_feat;
    logic                do_classify;
    split_entry_t        wr_entry;
    walk_req_t           req;
    walk_stat_t          stat;
    logic                res_ready;

    logic                tbl_rd_en;
    logic [TAW-1:0]      tbl_rd_addr;
    split_entry_t        tbl_rd_data;
    logic [CNTW-1:0]     count;
    logic                feat_rd_en;
    logic [FIDX_W-1:0]   feat_rd_idx;
    logic [VAL_W-1:0]    feat_rd_data;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [31:0]         m_tdata_reg,  m_tdata_next;

    // new transactions only while the walker is not busy
    assign s_tready = stat.idle;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        do_clear    = 1'b0;
        do_append   = 1'b0;
        do_wr_feat  = 1'b0;
        do_classify = 1'b0;
        case (func)
            FUNC_CLEAR:    do_clear    = accept;
            FUNC_APPEND:   do_append   = accept;
            FUNC_WR_FEAT:  do_wr_feat  = accept;
            FUNC_CLASSIFY: do_classify = accept;
            default:       do_clear    = 1'b0;
        endcase
    end

    always_comb begin
        wr_entry.parent    = node_id;
        wr_entry.feature   = feature_index;
        wr_entry.threshold = threshold;
        wr_entry.left_cls  = left_cls;
        wr_entry.right_cls = right_cls;
        req.start          = do_classify;
        req.in_bag         = in_bag;
    end

    dti_split_table #(
        .MAX_SPLITS (MAX_SPLITS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (do_clear),
        .append   (do_append),
        .wr_entry (wr_entry),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .rd_data  (tbl_rd_data),
        .count    (count)
    );

    dti_feature_store #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_feat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (do_wr_feat),
        .wr_idx  (feature_index),
        .wr_data (feature_value),
        .rd_en   (feat_rd_en),
        .rd_idx  (feat_rd_idx),
        .rd_data (feat_rd_data)
    );

    dti_walker #(
        .MAX_SPLITS (MAX_SPLITS),
        .NODE_BITS  (NODE_BITS)
    ) u_walk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (req),
        .res_ready    (res_ready),
        .count        (count),
        .tbl_rd_en    (tbl_rd_en),
        .tbl_rd_addr  (tbl_rd_addr),
        .tbl_rd_data  (tbl_rd_data),
        .feat_rd_en   (feat_rd_en),
        .feat_rd_idx  (feat_rd_idx),
        .feat_rd_data (feat_rd_data),
        .stat         (stat)
    );

    // output register: result parks here so the walker can take the next item
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (stat.res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0, stat.leaf_node, stat.valid_res, stat.predicted_class};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/dti_checker.sv =====
// Port-level checker for the decision tree block, bound to the top level
`include "decision_tree_inference_defines.svh"

module dti_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata
);
    import dti_pkg::*;

    `DTI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `DTI_ASSERT_SAME(a_no_pred_shape, aclk, aresetn, m_tvalid && !m_tdata[8], (m_tdata[7:0] == 8'd0) && ((m_tdata[24:9] == 16'd0) || (m_tdata[24:9] == 16'd1)), "invalid result carries class or deep leaf")
    `DTI_ASSERT_SAME(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[31:25] == 7'd0, "result pad bits set")
    `DTI_ASSERT_NEXT(a_classify_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser == FUNC_CLASSIFY), !s_tready, "input ready straight after classify")

endmodule

bind decision_tree_inference dti_checker u_dti_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the decision tree inference block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dti_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TARGET_ITEMS = 850;
    // Longest classify is a full table scan plus pipeline overhead
    localparam int SETTLE_CYCLES = DTI_MAX_SPLITS + 40;

    // One input transaction, fields as the block sees them
    typedef struct {
        func_t       op;
        logic [15:0] node_id;
        logic [5:0]  fidx;
        logic [31:0] thr;
        logic [7:0]  cl;
        logic [7:0]  cr;
        logic [31:0] fval;
        logic        in_bag;
    } tree_item_t;

    // One classification outcome
    typedef struct packed {
        logic [7:0]  cls;
        logic        ok;
        logic [15:0] leaf;
    } verdict_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = FUNC_CLEAR;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;

    // Shadow of the block's split table and feature store
    logic [15:0]        tbl_parent [DTI_MAX_SPLITS];
    logic [5:0]         tbl_feat   [DTI_MAX_SPLITS];
    logic signed [31:0] tbl_thr    [DTI_MAX_SPLITS];
    logic [7:0]         tbl_cl     [DTI_MAX_SPLITS];
    logic [7:0]         tbl_cr     [DTI_MAX_SPLITS];
    int unsigned        split_count = 0;
    logic signed [31:0] feat_mem   [DTI_NUM_FEATURES + 1];

    verdict_t pending_verdicts [$];
    int       mismatch_count = 0;
    int       items_sent     = 0;
    int       cycle_count    = 0;
    bit       no_idle        = 1'b0;

    decision_tree_inference dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Random fields throughout; callers override what matters
    function automatic tree_item_t rand_item(input func_t op);
        tree_item_t it;
        it.op      = op;
        it.node_id = 16'($urandom_range(0, 16'hFFFF));
        it.fidx    = 6'($urandom_range(0, 63));
        it.thr     = $urandom();
        it.cl      = 8'($urandom_range(0, 255));
        it.cr      = 8'($urandom_range(0, 255));
        it.fval    = $urandom();
        it.in_bag  = ($urandom_range(0, 99) < 15);
        return it;
    endfunction

    // Q16.16 value with a bias towards the extremes, zero and plus or minus unity
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0001_0000;
            3: return 32'hFFFF_0000;
            4: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Update the shadow state; classify transactions queue their outcome
    task automatic predict_item(input tree_item_t it);
        verdict_t           v;
        logic [15:0]        node;
        logic signed [31:0] x;
        case (it.op)
            FUNC_CLEAR: begin
                split_count = 0;   // entry contents stay behind
            end
            FUNC_APPEND: begin
                if (split_count < DTI_MAX_SPLITS) begin
                    tbl_parent[split_count] = it.node_id;
                    tbl_feat[split_count]   = it.fidx;
                    tbl_thr[split_count]    = it.thr;
                    tbl_cl[split_count]     = it.cl;
                    tbl_cr[split_count]     = it.cr;
                    split_count++;
                end
            end
            FUNC_WR_FEAT: begin
                if (it.fidx <= DTI_NUM_FEATURES)
                    feat_mem[it.fidx] = it.fval;
            end
            default: begin
                v = '0;
                if (!it.in_bag) begin
                    node = 16'd1;
                    for (int j = 0; j < split_count; j++) begin
                        if (node == tbl_parent[j]) begin
                            x = (tbl_feat[j] <= DTI_NUM_FEATURES) ? feat_mem[tbl_feat[j]] : '0;
                            // doubling wraps in 16 bits
                            if (x > tbl_thr[j]) begin
                                node  = {node[14:0], 1'b1};
                                v.cls = tbl_cr[j];
                            end else begin
                                node  = {node[14:0], 1'b0};
                                v.cls = tbl_cl[j];
                            end
                            v.ok = 1'b1;
                        end
                    end
                    v.leaf = node;
                end
                pending_verdicts.push_back(v);
            end
        endcase
    endtask

    // Present one transaction, hold it until accepted, then maybe go idle
    task automatic send_item(input tree_item_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {1'b0, it.in_bag, it.fval, it.cr, it.cl, it.thr, it.fidx, it.node_id};
        do @(posedge aclk); while (!s_tready);
        predict_item(it);
        items_sent++;
        if (!no_idle && $urandom_range(0, 99) < 10) begin
            // short random gap
            gap = $urandom_range(1, 2);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Sender holds off until every queued outcome has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic send_op(input func_t op);
        send_item(rand_item(op));
    endtask

    task automatic send_feature(input logic [5:0] slot, input logic [31:0] val);
        tree_item_t it;
        it      = rand_item(FUNC_WR_FEAT);
        it.fidx = slot;
        it.fval = val;
        send_item(it);
    endtask

    task automatic send_split(input logic [15:0] parent, input logic [5:0] slot,
                              input logic [31:0] thr, input logic [7:0] cl,
                              input logic [7:0] cr);
        tree_item_t it;
        it         = rand_item(FUNC_APPEND);
        it.node_id = parent;
        it.fidx    = slot;
        it.thr     = thr;
        it.cl      = cl;
        it.cr      = cr;
        send_item(it);
    endtask

    task automatic send_classify(input logic in_bag);
        tree_item_t it;
        it        = rand_item(FUNC_CLASSIFY);
        it.in_bag = in_bag;
        send_item(it);
    endtask

    // Hand-picked cases: empty table, in-bag, ties, extremes, clear
    task automatic test_directed();
        send_classify(1'b0);                        // empty table: leaf 1, not valid
        send_classify(1'b1);                        // in-bag: all zero
        send_feature(6'd0, 32'h8000_0000);          // slot 0 is ordinary
        send_feature(6'd63, 32'h7FFF_FFFF);
        send_split(16'd1, 6'd0, 32'h8000_0000, 8'hFF, 8'h00);  // tie goes left
        send_split(16'd2, 6'd63, 32'h7FFF_FFFE, 8'h00, 8'hFF); // just above: right
        send_split(16'd5, 6'd63, 32'h7FFF_FFFF, 8'h5A, 8'hA5); // tie at max
        send_split(16'hFFFF, 6'd1, 32'h0, 8'h11, 8'h22);       // never reached
        send_classify(1'b0);
        send_classify(1'b1);
        send_feature(6'd63, 32'h0);
        send_classify(1'b0);
        send_op(FUNC_CLEAR);
        send_classify(1'b0);                        // cleared: back to no split
        send_split(16'd1, 6'd63, 32'hFFFF_0000, 8'h01, 8'h02); // overwrites entry 0
        send_classify(1'b0);
    endtask

    // Chains that follow the taken path, most of them deep enough for node ids to wrap
    task automatic test_deep_chains();
        logic [15:0] node;
        logic [5:0]  slot;
        logic [31:0] thr;
        int          depth;
        repeat (6) begin
            send_op(FUNC_CLEAR);
            repeat (4) send_feature(6'($urandom_range(0, 63)), pick_q16());
            node  = 16'd1;
            depth = $urandom_range(15, 22);
            for (int lvl = 0; lvl < depth; lvl++) begin
                slot = 6'($urandom_range(0, 63));
                thr  = pick_q16();
                send_split(node, slot, thr, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
                node = {node[14:0], feat_mem[slot] > $signed(thr)};
            end
            send_classify(1'b0);
            send_feature(6'($urandom_range(0, 63)), pick_q16());
            send_classify(1'b0);
        end
    endtask

    // Fill the table, then push appends that must be dropped; no idling here
    task automatic test_table_full();
        logic [15:0] known [$];
        logic [15:0] parent;
        no_idle = 1'b1;
        send_op(FUNC_CLEAR);
        repeat (8) send_feature(6'($urandom_range(0, 63)), pick_q16());
        known = '{16'd1};
        repeat (DTI_MAX_SPLITS + 8) begin
            parent = ($urandom_range(0, 99) < 90) ? known[$urandom_range(0, known.size() - 1)]
                                                  : 16'($urandom_range(0, 16'hFFFF));
            known.push_back({parent[14:0], 1'b0});
            known.push_back({parent[14:0], 1'b1});
            send_split(parent, 6'($urandom_range(0, 63)), pick_q16(),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        repeat (3) begin
            send_classify(1'b0);
            send_feature(6'($urandom_range(0, 63)), pick_q16());
        end
        send_classify(1'b1);
        no_idle = 1'b0;
    endtask

    // One random tree: build it, then classify several observations against it
    task automatic run_tree_sequence();
        logic [15:0] known [$];
        logic [15:0] parent;
        int          n_splits;
        if ($urandom_range(0, 99) < 80)
            send_op(FUNC_CLEAR);
        repeat ($urandom_range(0, 6)) send_feature(6'($urandom_range(0, 63)), pick_q16());
        known    = '{16'd1};
        n_splits = $urandom_range(1, 24);
        repeat (n_splits) begin
            parent = ($urandom_range(0, 99) < 85) ? known[$urandom_range(0, known.size() - 1)]
                                                  : 16'($urandom_range(0, 16'hFFFF));
            known.push_back({parent[14:0], 1'b0});
            known.push_back({parent[14:0], 1'b1});
            send_split(parent, 6'($urandom_range(0, 63)), pick_q16(),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            // stray transaction of any kind, clear and classify included
            if ($urandom_range(0, 99) < 5)
                send_op(func_t'($urandom_range(0, 3)));
        end
        repeat ($urandom_range(1, 6)) begin
            repeat ($urandom_range(0, 3))
                send_feature(6'($urandom_range(0, 63)), pick_q16());
            send_classify($urandom_range(0, 99) < 15);
        end
    endtask

    task automatic test_random_trees();
        while (items_sent < TARGET_ITEMS) run_tree_sequence();
    endtask

    // Receiver: random back-pressure, and each result checked in order
    always @(posedge aclk) begin : check_results
        verdict_t want;
        m_tready <= no_idle || ($urandom_range(0, 99) >= 10);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[7:0] !== want.cls)
                    report_mismatch($sformatf("predicted_class %h, want %h",
                                              m_tdata[7:0], want.cls));
                if (m_tdata[8] !== want.ok)
                    report_mismatch($sformatf("valid_res %b, want %b", m_tdata[8], want.ok));
                if (m_tdata[24:9] !== want.leaf)
                    report_mismatch($sformatf("leaf_node %h, want %h",
                                              m_tdata[24:9], want.leaf));
            end
        end
    end

    initial begin
        for (int i = 0; i <= DTI_NUM_FEATURES; i++) feat_mem[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        wait_drained();
        test_deep_chains();
        test_table_full();
        wait_drained();
        test_random_trees();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/dti_pkg.sv
src/dti_split_table.sv
src/dti_feature_store.sv
src/dti_walker.sv
src/decision_tree_inference.sv
src/dti_checker.sv
tb/testbench.sv
